// ===== hw/rtl/khsb_pkg.sv =====
// Shared types and constants of the keyframe Hermite segment builder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package khsb_pkg;

   localparam int QW = 32;
   localparam int CW = 48;
   localparam int DivSteps = 49;

   localparam logic [2:0] MODE_SMOOTH = 3'd0;
   localparam logic [2:0] MODE_FLAT   = 3'd1;
   localparam logic [2:0] MODE_LINEAR = 3'd2;
   localparam logic [2:0] MODE_STEP   = 3'd3;
   localparam logic [2:0] MODE_FIXED  = 3'd4;

   // quotient selectors: older to new, older to middle, middle to new
   localparam logic [1:0] DIV_ACROSS = 2'd0;
   localparam logic [1:0] DIV_LEFT   = 2'd1;
   localparam logic [1:0] DIV_RIGHT  = 2'd2;

   localparam logic [30:0] SLOPE_LIMIT_RESET = 31'd1376256;

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_DIV_START = 9'b000000010,
      S_DIV_RUN   = 9'b000000100,
      S_TAN       = 9'b000001000,
      S_MUL1      = 9'b000010000,
      S_MUL2      = 9'b000100000,
      S_SUM       = 9'b001000000,
      S_EMIT      = 9'b010000000,
      S_COMMIT    = 9'b100000000
   } state_type;

   typedef struct packed {
      logic       load_key;
      logic       store_first;
      logic       div_start;
      logic       div_capture;
      logic [1:0] div_idx;
      logic       tan_en;
      logic       mul_sel;
      logic       mul_en;
      logic       sum_en;
      logic       emit;
      logic       seg_sel;
      logic       commit;
   } cmd_type;

   typedef struct packed {
      logic first_key;
      logic has_prev;
      logic final_key;
      logic div_done;
      logic rsp_free;
   } status_type;

endpackage

// ===== hw/rtl/khsb_divider.sv =====
// Bit-serial signed Q16.16 divider with saturation, one quotient bit a cycle.
// Depends on khsb_pkg.
`timescale 1ns / 1ps
module khsb_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] num,
   input  logic [32:0] den,
   output logic [31:0] result,
   output logic        done
);
   import khsb_pkg::*;

   logic [48:0] work_ff, work_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] dmag_ff, dmag_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic        neg_ff, num_neg_ff, num_zero_ff, den_zero_ff;
   logic [32:0] nmag;
   logic [33:0] rem_sh;
   logic        fits;

   assign nmag   = num[32] ? (~num + 33'd1) : num;
   assign rem_sh = {rem_ff, work_ff[48]};
   assign fits   = rem_sh >= {1'b0, dmag_ff};

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      dmag_in = dmag_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = done_ff;
      if (start) begin
         work_in = {nmag, 16'd0};
         rem_in  = '0;
         dmag_in = den[32] ? (~den + 33'd1) : den;
         cnt_in  = 6'(DivSteps - 1);
         run_in  = 1'b1;
         done_in = 1'b0;
      end else if (run_ff) begin
         rem_in  = fits ? 33'(rem_sh - {1'b0, dmag_ff}) : rem_sh[32:0];
         work_in = {work_ff[47:0], fits};
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      cnt_ff  <= cnt_in;
      if (start) begin
         neg_ff      <= num[32] ^ den[32];
         num_neg_ff  <= num[32];
         num_zero_ff <= (num == 33'd0);
         den_zero_ff <= (den == 33'd0);
      end
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_comb begin
      priority if (den_zero_ff) begin
         result = num_zero_ff ? 32'd0 : (num_neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF);
      end else if (neg_ff) begin
         result = (work_ff > 49'h0_8000_0000) ? 32'h8000_0000 : (~work_ff[31:0] + 32'd1);
      end else begin
         result = (work_ff > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : work_ff[31:0];
      end
   end

   assign done = done_ff;

endmodule

// ===== hw/rtl/khsb_datapath.sv =====
// Datapath: key window, slope clamp, quotient and tangent registers,
// shared multiplier, coefficient sums and the result register. Uses khsb_pkg.
`timescale 1ns / 1ps
module khsb_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  khsb_pkg::cmd_type    cmd,
   output khsb_pkg::status_type status,
   input  logic [135:0]         req_tdata,
   input  logic                 req_tlast,
   input  logic                 csr_we,
   input  logic [30:0]          csr_wdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [175:0]         rsp_tdata,
   output logic                 rsp_tlast
);
   import khsb_pkg::*;

   logic [30:0] limit_ff;
   logic [31:0] older_time_ff, older_value_ff, older_tan_ff;
   logic [2:0]  older_mode_ff;
   logic [31:0] mid_time_ff, mid_value_ff, mid_ls_ff, mid_rs_ff;
   logic [2:0]  mid_lm_ff, mid_rm_ff;
   logic [1:0]  keys_ff;
   logic [31:0] new_time_ff, new_value_ff, new_ls_ff, new_rs_ff;
   logic [2:0]  new_lm_ff, new_rm_ff;
   logic        new_fin_ff;
   logic [31:0] q_across_ff, q_left_ff, q_right_ff;
   logic [31:0] lt_mid_ff, rt_mid_ff, lt_new_ff;
   logic [64:0] prod_ff;
   logic [48:0] p1_ff, p2_ff;
   logic        rsp_valid_ff;
   logic [175:0] rsp_data_ff;
   logic        rsp_last_ff;

   logic [31:0] in_time, in_value, in_ls, in_rs, cl_ls, cl_rs;
   logic [2:0]  in_lm, in_rm;
   logic [32:0] dnum, dden;
   logic [31:0] qres;
   logic        qdone;
   logic [31:0] lt_mid, rt_mid, lt_new;
   logic [31:0] s_t0, s_a, s_tan_o, s_t1, s_b, s_tan_i, mtan;
   logic [2:0]  s_mode;
   logic [32:0] span;
   logic [64:0] prod, prod_adj;
   logic [48:0] pr;
   logic [52:0] a53, b53, p153, p253, c0w, c1w;
   logic [47:0] c0, c1, c2;

   function automatic logic [31:0] clamp(input logic [31:0] s, input logic [30:0] lim);
      logic [32:0] s33, l33, n33;
      s33 = {s[31], s};
      l33 = {2'b00, lim};
      n33 = ~l33 + 33'd1;
      if ($signed(s33) > $signed(l33)) return l33[31:0];
      else if ($signed(s33) < $signed(n33)) return n33[31:0];
      else return s;
   endfunction

   function automatic logic [32:0] sdiff(input logic [31:0] x, input logic [31:0] y);
      return {x[31], x} - {y[31], y};
   endfunction

   function automatic logic [47:0] sat48(input logic [52:0] v);
      if (!v[52] && (v[51:47] != 5'b00000)) return 48'h7FFF_FFFF_FFFF;
      else if (v[52] && (v[51:47] != 5'b11111)) return 48'h8000_0000_0000;
      else return v[47:0];
   endfunction

   assign in_time  = req_tdata[31:0];
   assign in_value = req_tdata[63:32];
   assign in_lm    = req_tdata[66:64];
   assign in_rm    = req_tdata[69:67];
   assign in_ls    = req_tdata[101:70];
   assign in_rs    = req_tdata[133:102];
   assign cl_ls    = clamp(in_ls, limit_ff);
   assign cl_rs    = clamp(in_rs, limit_ff);

   always_comb begin
      unique case (cmd.div_idx)
         DIV_LEFT: begin
            dnum = sdiff(mid_value_ff, older_value_ff);
            dden = sdiff(mid_time_ff, older_time_ff);
         end
         DIV_RIGHT: begin
            dnum = sdiff(new_value_ff, mid_value_ff);
            dden = sdiff(new_time_ff, mid_time_ff);
         end
         default: begin
            dnum = sdiff(new_value_ff, older_value_ff);
            dden = sdiff(new_time_ff, older_time_ff);
         end
      endcase
   end

   khsb_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_start),
      .num    (dnum),
      .den    (dden),
      .result (qres),
      .done   (qdone)
   );

   always_comb begin
      unique case (mid_lm_ff)
         MODE_SMOOTH: lt_mid = q_across_ff;
         MODE_LINEAR: lt_mid = q_left_ff;
         MODE_FIXED:  lt_mid = mid_ls_ff;
         default:     lt_mid = '0;
      endcase
      unique case (mid_rm_ff)
         MODE_SMOOTH: rt_mid = (keys_ff == 2'd2) ? q_across_ff : '0;
         MODE_LINEAR: rt_mid = q_right_ff;
         MODE_FIXED:  rt_mid = mid_rs_ff;
         default:     rt_mid = '0;
      endcase
      unique case (new_lm_ff)
         MODE_LINEAR: lt_new = q_right_ff;
         MODE_FIXED:  lt_new = new_ls_ff;
         default:     lt_new = '0;
      endcase
   end

   // segment operands: older to middle, or middle to the new key
   always_comb begin
      if (cmd.seg_sel) begin
         s_t0 = mid_time_ff;  s_a = mid_value_ff;  s_tan_o = rt_mid_ff;  s_mode = mid_rm_ff;
         s_t1 = new_time_ff;  s_b = new_value_ff;  s_tan_i = lt_new_ff;
      end else begin
         s_t0 = older_time_ff; s_a = older_value_ff; s_tan_o = older_tan_ff;
         s_mode = older_mode_ff;
         s_t1 = mid_time_ff;   s_b = mid_value_ff;   s_tan_i = lt_mid_ff;
      end
   end

   assign span     = sdiff(s_t1, s_t0);
   assign mtan     = cmd.mul_sel ? s_tan_i : s_tan_o;
   assign prod     = $signed({{32{span[32]}}, span}) * $signed({{33{mtan[31]}}, mtan});
   // truncate toward zero on the drop of sixteen fraction bits
   assign prod_adj = prod_ff + (prod_ff[64] ? 65'd65535 : 65'd0);
   assign pr       = prod_adj[64:16];

   assign a53  = {{21{s_a[31]}}, s_a};
   assign b53  = {{21{s_b[31]}}, s_b};
   assign p153 = {{4{p1_ff[48]}}, p1_ff};
   assign p253 = {{4{p2_ff[48]}}, p2_ff};
   assign c0w  = (a53 << 1) - (b53 << 1) + p153 + p253;
   assign c1w  = (b53 << 1) + b53 - (a53 << 1) - a53 - (p153 << 1) - p253;
   assign c0   = (s_mode == MODE_STEP) ? '0 : sat48(c0w);
   assign c1   = (s_mode == MODE_STEP) ? '0 : sat48(c1w);
   assign c2   = (s_mode == MODE_STEP) ? '0 : p1_ff[47:0];

   always_ff @(posedge clock) begin
      if (cmd.load_key) begin
         new_time_ff  <= in_time;
         new_value_ff <= in_value;
         new_lm_ff    <= in_lm;
         new_rm_ff    <= in_rm;
         new_ls_ff    <= cl_ls;
         new_rs_ff    <= cl_rs;
         new_fin_ff   <= req_tlast;
      end
      if (cmd.div_capture) begin
         unique case (cmd.div_idx)
            DIV_LEFT:  q_left_ff   <= qres;
            DIV_RIGHT: q_right_ff  <= qres;
            default:   q_across_ff <= qres;
         endcase
      end
      if (cmd.tan_en) begin
         lt_mid_ff <= lt_mid;
         rt_mid_ff <= rt_mid;
         lt_new_ff <= lt_new;
      end
      if (cmd.mul_en) prod_ff <= prod;
      if (cmd.mul_en && cmd.mul_sel) p1_ff <= pr;
      if (cmd.sum_en) p2_ff <= pr;
      if (cmd.emit) begin
         rsp_data_ff <= {s_a, c2, c1, c0};
         rsp_last_ff <= cmd.seg_sel;
      end
      if (reset) begin
         limit_ff       <= SLOPE_LIMIT_RESET;
         older_time_ff  <= '0;
         older_value_ff <= '0;
         older_tan_ff   <= '0;
         older_mode_ff  <= '0;
         mid_time_ff    <= '0;
         mid_value_ff   <= '0;
         mid_lm_ff      <= '0;
         mid_rm_ff      <= '0;
         mid_ls_ff      <= '0;
         mid_rs_ff      <= '0;
         keys_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) limit_ff <= csr_wdata;
         if (cmd.store_first) begin
            mid_time_ff  <= in_time;
            mid_value_ff <= in_value;
            mid_lm_ff    <= in_lm;
            mid_rm_ff    <= in_rm;
            mid_ls_ff    <= cl_ls;
            mid_rs_ff    <= cl_rs;
            keys_ff      <= req_tlast ? 2'd0 : 2'd1;
         end
         if (cmd.commit) begin
            older_time_ff  <= mid_time_ff;
            older_value_ff <= mid_value_ff;
            older_tan_ff   <= rt_mid_ff;
            older_mode_ff  <= mid_rm_ff;
            mid_time_ff    <= new_time_ff;
            mid_value_ff   <= new_value_ff;
            mid_lm_ff      <= new_lm_ff;
            mid_rm_ff      <= new_rm_ff;
            mid_ls_ff      <= new_ls_ff;
            mid_rs_ff      <= new_rs_ff;
            keys_ff        <= new_fin_ff ? 2'd0 : 2'd2;
         end
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign status.first_key = (keys_ff == 2'd0);
   assign status.has_prev  = (keys_ff == 2'd2);
   assign status.final_key = new_fin_ff;
   assign status.div_done  = qdone;
   assign status.rsp_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hw/rtl/khsb_controller.sv =====
// Controller: sequences divisions, tangent selection, products and emission
// for each accepted key after the first of a curve. Uses khsb_pkg.
`timescale 1ns / 1ps
module khsb_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  khsb_pkg::status_type status,
   output khsb_pkg::cmd_type    cmd
);
   import khsb_pkg::*;

   state_type   state_ff, state_in;
   logic [1:0]  idx_ff, idx_in;
   logic        seg_ff, seg_in;
   logic        accept;

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      seg_in   = seg_ff;
      cmd      = '0;
      cmd.div_idx = idx_ff;
      cmd.seg_sel = seg_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.store_first = status.first_key;
               cmd.load_key    = !status.first_key;
               idx_in          = DIV_ACROSS;
               if (!status.first_key) state_in = S_DIV_START;
            end
         end
         S_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_RUN;
         end
         S_DIV_RUN: begin
            if (status.div_done) begin
               cmd.div_capture = 1'b1;
               if (idx_ff == DIV_RIGHT) begin
                  state_in = S_TAN;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = S_DIV_START;
               end
            end
         end
         S_TAN: begin
            cmd.tan_en = 1'b1;
            seg_in     = !status.has_prev;
            if (status.has_prev || status.final_key) state_in = S_MUL1;
            else state_in = S_COMMIT;
         end
         S_MUL1: begin
            cmd.mul_en = 1'b1;
            state_in   = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = 1'b1;
            state_in    = S_SUM;
         end
         S_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            // hold until the result register frees up
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               if (!seg_ff && status.final_key) begin
                  seg_in   = 1'b1;
                  state_in = S_MUL1;
               end else begin
                  state_in = S_COMMIT;
               end
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      seg_ff <= seg_in;
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ===== hw/rtl/keyframe_hermite_segment_builder.sv =====
// Top level of the keyframe Hermite segment builder: controller plus datapath.
// Depends on khsb_pkg, khsb_controller, khsb_datapath, khsb_divider.
`timescale 1ns / 1ps
// Accepts one keyframe transaction at a time in time order and emits cubic
// Hermite segment coefficients. The first key of a curve is stored as it is
// accepted. Every later key runs three serial 49-step divisions, each with a
// start and a capture state, then a tangent step, then two products and a sum
// per emitted segment on the shared multiplier, and a commit: the input is
// ready again only in idle, so a new key is not taken before the last one is
// through. A result waiting in the output register stalls the next emission,
// and with it the return to idle. The input is not ready while reset is high.
module keyframe_hermite_segment_builder (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // key_time[31:0], key_value[63:32], left_mode[66:64], right_mode[69:67],
   // left_slope[101:70], right_slope[133:102], zero pad[135:134]
   input  logic [135:0]  req_tdata,
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // coef_cubic[47:0], coef_square[95:48], coef_linear[143:96],
   // coef_constant[175:144]
   output logic [175:0]  rsp_tdata,
   output logic          rsp_tlast,
   input  logic          csr_we,
   input  logic [30:0]   csr_wdata
);
   import khsb_pkg::*;

   cmd_type    cmd;
   status_type status;

   khsb_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   khsb_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
